// ===== sv/gcm_pkg.sv =====
`timescale 1ns / 1ps

package gcm_pkg;

  // table geometry and value width
  localparam int MAX_DENOMS = 16;
  localparam int CENT_BITS  = 20;
  localparam int IDX_BITS   = $clog2(MAX_DENOMS);
  localparam int CNT_BITS   = $clog2(MAX_DENOMS + 1);
  localparam int STAT_BITS  = 3;

  // stream word widths, padded to whole bytes
  localparam int S_DATA_W = ((CENT_BITS + 7) / 8) * 8;
  localparam int OUT_W    = STAT_BITS + 2 * CENT_BITS;
  localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [CENT_BITS-1:0] cents_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_COIN  = 3'd0,
    ST_ADDED = 3'd1,
    ST_DUP   = 3'd2,
    ST_LOW   = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_END,
    S_SH_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_CHG_RD,
    S_CHG_LD,
    S_CHG_DIV,
    S_EMIT
  } gcm_state_t;

  // divider request and response
  typedef struct packed {
    logic   start;
    cents_t dividend;
    cents_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    cents_t quotient;
    cents_t remainder;
  } div_rsp_t;

  // table contents after reset, for entries not yet written
  function automatic cents_t reset_denom(input logic [IDX_BITS-1:0] idx);
    cents_t v;
    case (idx)
      IDX_BITS'(0): v = CENT_BITS'(25);
      IDX_BITS'(1): v = CENT_BITS'(10);
      IDX_BITS'(2): v = CENT_BITS'(5);
      IDX_BITS'(3): v = CENT_BITS'(1);
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/greedy_change_maker.sv =====
`timescale 1ns / 1ps

// channel  dir  tdata (low bit up)                         side bands
// s        in   cents[19:0], zero pad to 24                tuser = req_type
// m        out  status[2:0], denomination, coin_count, pad tlast = last
//
// one request at a time; s_tready is high only while nothing is in flight
// add: reads and checks each stored denomination in turn, then moves each entry from
// the insertion slot on down one place and writes the new one; change: one division per
// stored denomination by the serial divider, for up to 16 in a full table
// rst is synchronous; the denomination table comes back as 25, 10, 5, 1
// a stalled m side holds the word and pauses the walk until it is taken

module greedy_change_maker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gcm_pkg::S_DATA_W-1:0]  s_tdata,   // cents
  input  logic                          s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gcm_pkg::M_DATA_W-1:0]  m_tdata,   // status, denomination, coin_count
  output logic                          m_tlast    // last
);

  localparam int CB  = gcm_pkg::CENT_BITS;
  localparam int IB  = gcm_pkg::IDX_BITS;
  localparam int NB  = gcm_pkg::CNT_BITS;
  localparam int MAXD = gcm_pkg::MAX_DENOMS;

  gcm_pkg::gcm_state_t state, state_next;

  logic [NB-1:0]          cnt;
  logic [NB-1:0]          idx;
  logic [NB-1:0]          pos;
  logic                   kind;
  gcm_pkg::cents_t        value;
  gcm_pkg::cents_t        remain;
  gcm_pkg::status_t       res_status;
  gcm_pkg::cents_t        res_denom;
  gcm_pkg::cents_t        res_count;
  logic                   res_last;
  logic [MAXD-1:0]        ent_valid;
  logic                   rd_valid;
  logic [IB-1:0]          rd_addr_q;

  logic                   ram_we;
  logic [IB-1:0]          ram_wr_addr;
  gcm_pkg::cents_t        ram_wr_data;
  logic                   ram_rd_en;
  logic [IB-1:0]          ram_rd_addr;
  gcm_pkg::cents_t        ram_rd_data;
  gcm_pkg::cents_t        rd_denom;

  gcm_pkg::div_req_t      div_req;
  gcm_pkg::div_rsp_t      div_rsp;

  logic                   in_fire;
  logic                   out_free;
  logic                   out_load;
  logic                   scan_end;
  logic [NB-1:0]          idx_dec;
  gcm_pkg::cents_t        in_cents;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_cents = s_tdata[CB-1:0];
  assign scan_end = (idx + 1'b1) == cnt;
  assign idx_dec  = idx - 1'b1;

  // denomination store
  gcm_ram #(
    .WIDTH (CB),
    .DEPTH (MAXD)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // serial divider for the change walk
  gcm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // entries never written read as their reset contents
  assign rd_denom = rd_valid ? ram_rd_data : gcm_pkg::reset_denom(rd_addr_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (ram_we) begin
      ent_valid[ram_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      rd_addr_q <= ram_rd_addr;
      rd_valid  <= ent_valid[ram_rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gcm_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_cents == '0) begin
            state_next = gcm_pkg::S_EMIT;
          end else if (s_tuser) begin
            state_next = gcm_pkg::S_CHG_RD;
          end else begin
            state_next = gcm_pkg::S_ADD_RD;
          end
        end
      end
      gcm_pkg::S_ADD_RD:  state_next = gcm_pkg::S_ADD_CHK;
      gcm_pkg::S_ADD_CHK: begin
        if (rd_denom == value) begin
          state_next = gcm_pkg::S_EMIT;
        end else if (scan_end) begin
          state_next = gcm_pkg::S_ADD_END;
        end else begin
          state_next = gcm_pkg::S_ADD_RD;
        end
      end
      gcm_pkg::S_ADD_END: begin
        if (cnt == NB'(MAXD)) begin
          state_next = gcm_pkg::S_EMIT;
        end else begin
          state_next = gcm_pkg::S_SH_CHK;
        end
      end
      gcm_pkg::S_SH_CHK:  state_next = (idx > pos) ? gcm_pkg::S_SH_RD : gcm_pkg::S_INS;
      gcm_pkg::S_SH_RD:   state_next = gcm_pkg::S_SH_WR;
      gcm_pkg::S_SH_WR:   state_next = gcm_pkg::S_SH_CHK;
      gcm_pkg::S_INS:     state_next = gcm_pkg::S_EMIT;
      gcm_pkg::S_CHG_RD:  state_next = gcm_pkg::S_CHG_LD;
      gcm_pkg::S_CHG_LD:  state_next = gcm_pkg::S_CHG_DIV;
      gcm_pkg::S_CHG_DIV: begin
        if (div_rsp.done) begin
          state_next = gcm_pkg::S_EMIT;
        end
      end
      gcm_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = res_last ? gcm_pkg::S_IDLE : gcm_pkg::S_CHG_RD;
        end
      end
      default: state_next = gcm_pkg::S_IDLE;
    endcase
  end

  // memory, divider and handshake controls
  always_comb begin
    s_tready         = 1'b0;
    ram_we           = 1'b0;
    ram_wr_addr      = idx[IB-1:0];
    ram_wr_data      = rd_denom;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = idx[IB-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = remain;
    div_req.divisor  = rd_denom;
    out_load         = 1'b0;
    case (state)
      gcm_pkg::S_IDLE:   s_tready = 1'b1;
      gcm_pkg::S_ADD_RD: ram_rd_en = 1'b1;
      gcm_pkg::S_SH_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_dec[IB-1:0];
      end
      gcm_pkg::S_SH_WR:  ram_we = 1'b1;
      gcm_pkg::S_INS: begin
        ram_we      = 1'b1;
        ram_wr_addr = pos[IB-1:0];
        ram_wr_data = value;
      end
      gcm_pkg::S_CHG_RD: ram_rd_en = 1'b1;
      gcm_pkg::S_CHG_LD: div_req.start = 1'b1;
      gcm_pkg::S_EMIT:   out_load = out_free;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcm_pkg::S_IDLE;
      cnt   <= NB'(4);
    end else begin
      state <= state_next;
      if (state == gcm_pkg::S_INS) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      gcm_pkg::S_IDLE: begin
        if (in_fire) begin
          kind       <= s_tuser;
          value      <= in_cents;
          remain     <= in_cents;
          idx        <= '0;
          pos        <= cnt;
          res_status <= gcm_pkg::ST_LOW;
          res_denom  <= '0;
          res_count  <= '0;
          res_last   <= 1'b1;
        end
      end
      gcm_pkg::S_ADD_CHK: begin
        // duplicate check and first slot holding a smaller value
        if (rd_denom == value) begin
          res_status <= gcm_pkg::ST_DUP;
          res_denom  <= value;
        end
        if (value > rd_denom && pos == cnt) begin
          pos <= idx;
        end
        idx <= idx + 1'b1;
      end
      gcm_pkg::S_ADD_END: begin
        res_status <= gcm_pkg::ST_FULL;
        res_denom  <= value;
        idx        <= cnt;
      end
      gcm_pkg::S_SH_WR:  idx <= idx_dec;
      gcm_pkg::S_INS: begin
        res_status <= gcm_pkg::ST_ADDED;
        res_denom  <= value;
      end
      gcm_pkg::S_CHG_LD: begin
        res_denom <= rd_denom;
      end
      gcm_pkg::S_CHG_DIV: begin
        if (div_rsp.done) begin
          res_status <= gcm_pkg::ST_COIN;
          res_count  <= div_rsp.quotient;
          remain     <= div_rsp.remainder;
          res_last   <= scan_end;
        end
      end
      gcm_pkg::S_EMIT: begin
        if (out_free && kind) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= gcm_pkg::M_DATA_W'({res_count, res_denom, res_status});
      m_tlast <= res_last;
    end
  end

endmodule

// ===== sv/gcm_ram.sv =====
`timescale 1ns / 1ps

module gcm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/gcm_div.sv =====
`timescale 1ns / 1ps

module gcm_div (
  input  logic              clk,
  input  logic              rst,
  input  gcm_pkg::div_req_t req,
  output gcm_pkg::div_rsp_t rsp
);

  localparam int CB     = gcm_pkg::CENT_BITS;
  localparam int STEP_W = $clog2(CB + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CB-1:0]     rem;
  logic [CB-1:0]     quo;
  logic [CB-1:0]     dvs;
  logic              done;
  logic [CB:0]       rem_sh;
  logic [CB:0]       trial;
  logic              fits;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh = {rem, quo[CB-1]};
  assign trial  = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in from the bottom as the dividend shifts out the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[CB-1:0] : rem_sh[CB-1:0];
      quo <= {quo[CB-2:0], fits};
    end
  end

  // a zero divisor gives no coins and leaves the amount untouched
  assign rsp.done      = done;
  assign rsp.quotient  = (dvs == '0) ? '0 : quo;
  assign rsp.remainder = rem;

endmodule

// ===== dv/greedy_change_maker_test.sv =====
`timescale 1ns / 1ps

module greedy_change_maker_test;
  import gcm_pkg::*;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_CHANGE = 1'b1;
  localparam int   N_RANDOM   = 207;

  // one result word as the block reports it
  typedef struct packed {
    status_t st;
    cents_t  denom;
    cents_t  coins;
    logic    last;
  } coin_word_t;

  // one directed request, with its single result typed in where known
  typedef struct packed {
    logic       kind;
    cents_t     amt;
    logic       typed;
    coin_word_t word;
  } dir_row_t;

  localparam coin_word_t NO_WORD = '{ST_COIN, 20'd0, 20'd0, 1'b0};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  // predicted table of denominations, largest first
  cents_t denoms [MAX_DENOMS];
  int     n_denoms;

  coin_word_t fresh_words [$];
  coin_word_t owed_words [$];
  int         n_mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  dir_row_t dir_rows [23];

  greedy_change_maker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_mismatches++;
  endtask

  // works out the words one request gives and updates the predicted table
  task automatic work_out_change(input logic kind, input cents_t amt);
    status_t    st;
    int         pos;
    cents_t     left;
    cents_t     q;
    coin_word_t w;
    if (kind == REQ_ADD) begin
      if (amt == 0) begin
        st = ST_LOW;
      end else begin
        st = ST_ADDED;
        for (int i = 0; i < n_denoms; i++) begin
          if (denoms[i] == amt) st = ST_DUP;
        end
        if (st == ST_ADDED && n_denoms >= MAX_DENOMS) st = ST_FULL;
      end
      if (st == ST_ADDED) begin
        // sorted insert: first slot holding a smaller value
        pos = n_denoms;
        for (int i = n_denoms - 1; i >= 0; i--) begin
          if (amt > denoms[i]) pos = i;
        end
        for (int i = n_denoms; i > pos; i--) denoms[i] = denoms[i-1];
        denoms[pos] = amt;
        n_denoms++;
      end
      w.st    = st;
      w.denom = (st == ST_LOW) ? cents_t'(0) : amt;
      w.coins = '0;
      w.last  = 1'b1;
      fresh_words = {fresh_words, w};
    end else if (amt == 0) begin
      w.st    = ST_LOW;
      w.denom = '0;
      w.coins = '0;
      w.last  = 1'b1;
      fresh_words = {fresh_words, w};
    end else begin
      // greedy walk, remainder after the smallest coin is dropped
      left = amt;
      for (int i = 0; i < n_denoms; i++) begin
        q       = left / denoms[i];
        left    = left - q * denoms[i];
        w.st    = ST_COIN;
        w.denom = denoms[i];
        w.coins = q;
        w.last  = (i == n_denoms - 1);
        fresh_words = {fresh_words, w};
      end
    end
  endtask

  // offers one request, with random gaps first, and books its results
  task automatic send_request(input logic kind, input cents_t amt, input logic typed,
                              input coin_word_t word);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tuser  <= 1'($urandom);
      s_tdata  <= S_DATA_W'(CENT_BITS'($urandom));
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_DATA_W'(amt);
    do @(posedge clk); while (!s_tready);
    work_out_change(kind, amt);
    if (typed) begin
      owed_words = {owed_words, word};
    end else begin
      owed_words = {owed_words, fresh_words};
    end
    fresh_words.delete();
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checking
  always @(posedge clk) begin : take_word
    coin_word_t got;
    coin_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.st    = status_t'(m_tdata[STAT_BITS-1:0]);
      got.denom = m_tdata[STAT_BITS +: CENT_BITS];
      got.coins = m_tdata[STAT_BITS+CENT_BITS +: CENT_BITS];
      got.last  = m_tlast;
      if (owed_words.size() == 0) begin
        flag_mismatch("word with none owed, status", got.st, 0);
      end else begin
        want = owed_words.pop_front();
        if (got.st !== want.st) flag_mismatch("status", got.st, want.st);
        if (got.denom !== want.denom) flag_mismatch("denomination", got.denom, want.denom);
        if (got.coins !== want.coins) flag_mismatch("coin_count", got.coins, want.coins);
        if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
      end
    end
  end

  initial begin : run
    dir_row_t row;
    logic     kind;
    cents_t   amt;
    int       r;

    foreach (denoms[i]) denoms[i] = '0;
    denoms[0] = 25;
    denoms[1] = 10;
    denoms[2] = 5;
    denoms[3] = 1;
    n_denoms  = 4;

    dir_rows = '{
      '{REQ_CHANGE, 20'd0,       1'b1, '{ST_LOW,   20'd0,       20'd0, 1'b1}},
      '{REQ_ADD,    20'd0,       1'b1, '{ST_LOW,   20'd0,       20'd0, 1'b1}},
      '{REQ_ADD,    20'd25,      1'b1, '{ST_DUP,   20'd25,      20'd0, 1'b1}},
      '{REQ_ADD,    20'd1,       1'b1, '{ST_DUP,   20'd1,       20'd0, 1'b1}},
      '{REQ_CHANGE, 20'd41,      1'b0, NO_WORD},
      '{REQ_CHANGE, 20'd1,       1'b0, NO_WORD},
      '{REQ_CHANGE, 20'hfffff,   1'b0, NO_WORD},
      '{REQ_ADD,    20'hfffff,   1'b1, '{ST_ADDED, 20'hfffff,   20'd0, 1'b1}},
      '{REQ_ADD,    20'd50,      1'b1, '{ST_ADDED, 20'd50,      20'd0, 1'b1}},
      '{REQ_ADD,    20'd2,       1'b1, '{ST_ADDED, 20'd2,       20'd0, 1'b1}},
      '{REQ_ADD,    20'd3,       1'b1, '{ST_ADDED, 20'd3,       20'd0, 1'b1}},
      '{REQ_ADD,    20'd100,     1'b1, '{ST_ADDED, 20'd100,     20'd0, 1'b1}},
      '{REQ_ADD,    20'd7,       1'b1, '{ST_ADDED, 20'd7,       20'd0, 1'b1}},
      '{REQ_ADD,    20'd20,      1'b1, '{ST_ADDED, 20'd20,      20'd0, 1'b1}},
      '{REQ_ADD,    20'd15,      1'b1, '{ST_ADDED, 20'd15,      20'd0, 1'b1}},
      '{REQ_ADD,    20'd12,      1'b1, '{ST_ADDED, 20'd12,      20'd0, 1'b1}},
      '{REQ_ADD,    20'd500,     1'b1, '{ST_ADDED, 20'd500,     20'd0, 1'b1}},
      '{REQ_ADD,    20'd524288,  1'b1, '{ST_ADDED, 20'd524288,  20'd0, 1'b1}},
      '{REQ_ADD,    20'd40,      1'b1, '{ST_ADDED, 20'd40,      20'd0, 1'b1}},
      '{REQ_ADD,    20'd1000,    1'b1, '{ST_FULL,  20'd1000,    20'd0, 1'b1}},
      '{REQ_ADD,    20'd7,       1'b1, '{ST_DUP,   20'd7,       20'd0, 1'b1}},
      '{REQ_CHANGE, 20'hfffff,   1'b0, NO_WORD},
      '{REQ_CHANGE, 20'd99,      1'b0, NO_WORD}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed table, no idling
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.kind, row.amt, row.typed, row.word);
    end

    // random requests over four idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 4) / N_RANDOM)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 20) begin
        kind = REQ_ADD;
        r = $urandom_range(0, 9);
        if (r < 4)      amt = denoms[$urandom_range(0, n_denoms - 1)];
        else if (r < 5) amt = '0;
        else            amt = CENT_BITS'($urandom);
      end else begin
        kind = REQ_CHANGE;
        r = $urandom_range(0, 99);
        if (r < 5)       amt = '0;
        else if (r < 35) amt = CENT_BITS'($urandom_range(1, 200));
        else if (r < 65) amt = CENT_BITS'($urandom_range(1, 5000));
        else             amt = CENT_BITS'($urandom);
      end
      send_request(kind, amt, 1'b0, NO_WORD);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then watch for stray words
    while (owed_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (n_mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gcm_pkg.sv
sv/gcm_ram.sv
sv/gcm_div.sv
sv/greedy_change_maker.sv
dv/greedy_change_maker_test.sv
